@@ design/opd_pkg.sv @@
// Shared types and constants for the Ogg page deframer.
package opd_pkg;

    localparam int OPD_MAX_SEGMENTS = 255;
    localparam int STREAM_LEN_W     = 40;
    localparam int FIT_W            = STREAM_LEN_W + 1;
    localparam int HDR_CNT_W        = 5;

    localparam logic [STREAM_LEN_W-1:0] POS_MAX = {STREAM_LEN_W{1'b1}};

    // "OggS", first byte in the lowest lane
    localparam logic [3:0][7:0] OGG_MAGIC = {8'h53, 8'h67, 8'h67, 8'h4F};

    localparam logic [HDR_CNT_W-1:0] HDR_MAGIC_HI  = 5'd3;
    localparam logic [HDR_CNT_W-1:0] HDR_VERSION   = 5'd4;
    localparam logic [HDR_CNT_W-1:0] HDR_FLAGS     = 5'd5;
    localparam logic [HDR_CNT_W-1:0] HDR_SERIAL_LO = 5'd14;
    localparam logic [HDR_CNT_W-1:0] HDR_SERIAL_HI = 5'd17;
    localparam logic [HDR_CNT_W-1:0] HDR_SEGS      = 5'd26;

    localparam int FLAG_CONT_BIT = 0;
    localparam int FLAG_BOS_BIT  = 1;

    localparam logic [7:0] SEG_FULL = 8'hFF;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LACING  = 2'd1,
        PH_PAYLOAD = 2'd2
    } opd_phase_t;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_HEADER = 2'd1,
        ERR_SERIAL = 2'd2,
        ERR_TRUNC  = 2'd3
    } opd_err_t;

    // One nonzero lacing value plus whether zero segments came right before it
    typedef struct packed {
        logic       zero_before;
        logic [7:0] len;
    } opd_entry_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] payload_byte;
        logic       packet_end;
        opd_err_t   error_code;
    } opd_result_t;

endpackage

@@ design/opd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module opd_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read from the address being written returns the old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/opd_out_buf.sv @@
// Two-entry result buffer between the deframer step logic and the output stream.
module opd_out_buf
    import opd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  opd_result_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output opd_result_t out_data
);

    logic [1:0]  cnt_reg, cnt_next;
    opd_result_t q0_reg, q0_next;
    opd_result_t q1_reg, q1_next;
    logic        push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = q0_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        case ({push, pop})
            2'b10:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd0)
                begin
                    q0_next = in_data;
                end
                else
                begin
                    q1_next = in_data;
                end
            end
            2'b01:
            begin
                cnt_next = cnt_reg - 2'd1;
                q0_next  = q1_reg;
            end
            2'b11:
            begin
                // only reachable with one item held
                q0_next = in_data;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

@@ design/ogg_page_packet_deframer_core.sv @@
// Ogg page deframer: header checks, lacing table in RAM, payload bytes out.
// Results pass through a two-entry output buffer to m_axis. Throughput: one item per
// cycle while that buffer has room; each step is one pass of header/lacing/payload logic;
// the next lacing entry is prefetched from the RAM's registered port or a bypass register.
// Reset (async, active low) clears all control state and sets stream_length to 2^40-1;
// the lacing RAM needs no clearing pass, only entries written on the current page are read.
module ogg_page_packet_deframer_core
    import opd_pkg::*;
#(
    parameter int MAX_SEGMENTS = OPD_MAX_SEGMENTS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [STREAM_LEN_W-1:0] cfg_data,       // stream_length
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [7:0]              s_axis_tdata,   // [7:0] data_byte
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [15:0]             m_axis_tdata,   // [7:0] payload_byte, [9:8] error_code
    output logic                    m_axis_tuser,   // [0] has_byte
    output logic                    m_axis_tlast    // packet_end
);

    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int ADDR_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    opd_phase_t              phase_reg, phase_next;
    logic [HDR_CNT_W-1:0]    hdr_cnt_reg, hdr_cnt_next;
    logic [31:0]             serial_reg, serial_next;
    logic                    serial_known_reg, serial_known_next;
    logic                    first_pending_reg, first_pending_next;
    logic [7:0]              seg_total_reg, seg_total_next;
    logic [7:0]              lace_cnt_reg, lace_cnt_next;
    logic [CNT_W-1:0]        nz_cnt_reg, nz_cnt_next;
    logic [CNT_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic                    zero_run_reg, zero_run_next;
    logic                    head_valid_reg, head_valid_next;
    opd_entry_t              head_reg, head_next;
    logic [7:0]              left_reg, left_next;
    logic                    cur_full_reg, cur_full_next;
    logic                    open_reg, open_next;
    logic [FIT_W-1:0]        fit_base_reg, fit_base_next;
    logic [STREAM_LEN_W-1:0] pos_reg, pos_next;
    logic [STREAM_LEN_W-1:0] len_reg, len_next;
    opd_err_t                err_reg, err_next;
    logic                    fwd_reg, fwd_next;
    opd_entry_t              fwd_data_reg;

    logic             fire, live, ok;
    logic [7:0]       b;
    logic [1:0]       ser_sel;
    opd_err_t         hdr_err, new_err;
    logic             lace_last, lace_fits, lace_nz;
    logic [FIT_W-1:0] fit_sum;
    logic             head_have_nx, zero_run_lace_nx;
    opd_entry_t       head_nx;
    opd_entry_t       mem_entry, ram_rdata, ram_wdata;
    logic             mem_have;
    logic             ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic             do_adv, adv_from_head, emit, end_mark, open_pre;
    logic             adv_have, adv_zero, adv_closed;
    opd_entry_t       adv_ent;
    opd_result_t      res;
    logic             buf_ready;
    opd_result_t      buf_out;

    assign b             = s_axis_tdata;
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = buf_ready;
    assign fire          = s_axis_tvalid && s_axis_tready;
    assign live          = (err_reg == ERR_OK);
    assign ok            = fire && live && (new_err == ERR_OK);
    assign ser_sel       = 2'(hdr_cnt_reg - HDR_SERIAL_LO);

    // ---------------- header byte checks ----------------
    always_comb
    begin
        hdr_err = ERR_OK;
        if (hdr_cnt_reg <= HDR_MAGIC_HI)
        begin
            if (b != OGG_MAGIC[hdr_cnt_reg[1:0]])
            begin
                hdr_err = ERR_HEADER;
            end
        end
        else if (hdr_cnt_reg == HDR_VERSION)
        begin
            if (b != 8'h00)
            begin
                hdr_err = ERR_HEADER;
            end
        end
        else if (hdr_cnt_reg == HDR_FLAGS)
        begin
            if (b[FLAG_CONT_BIT] != open_reg)
            begin
                hdr_err = ERR_HEADER;
            end
            else if (first_pending_reg && !b[FLAG_BOS_BIT])
            begin
                hdr_err = ERR_HEADER;
            end
        end
        else if (hdr_cnt_reg >= HDR_SERIAL_LO && hdr_cnt_reg <= HDR_SERIAL_HI)
        begin
            if (serial_known_reg && serial_reg[{ser_sel, 3'b000} +: 8] != b)
            begin
                hdr_err = ERR_SERIAL;
            end
        end
        else if (hdr_cnt_reg == HDR_SEGS)
        begin
            if (b > 8'(MAX_SEGMENTS))
            begin
                hdr_err = ERR_HEADER;
            end
        end
    end

    // ---------------- lacing byte handling ----------------
    // fit_base tracks byte position plus payload sum so far
    assign lace_last        = ({1'b0, lace_cnt_reg} + 9'd1) >= {1'b0, seg_total_reg};
    assign fit_sum          = fit_base_reg + FIT_W'(b) + FIT_W'(1);
    assign lace_fits        = fit_sum <= {1'b0, len_reg};
    assign lace_nz          = (b != 8'h00);
    assign head_have_nx     = head_valid_reg || lace_nz;
    assign head_nx          = head_valid_reg ? head_reg : '{zero_before: zero_run_reg, len: b};
    assign zero_run_lace_nx = !lace_nz;

    // RAM holds only nonzero segments; zero runs become the zero_before flag
    assign ram_wdata = '{zero_before: zero_run_reg, len: b};
    assign ram_waddr = nz_cnt_reg[ADDR_W-1:0];
    assign ram_raddr = rd_ptr_next[ADDR_W-1:0];
    assign mem_entry = fwd_reg ? fwd_data_reg : ram_rdata;
    assign mem_have  = (rd_ptr_reg < nz_cnt_reg);
    assign fwd_next  = ram_we && (ram_waddr == ram_raddr);

    always_comb
    begin
        new_err = ERR_OK;
        if (pos_reg >= len_reg)
        begin
            new_err = ERR_TRUNC;
        end
        else
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    new_err = hdr_err;
                end
                PH_LACING:
                begin
                    if (lace_last && !lace_fits)
                    begin
                        new_err = ERR_TRUNC;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- segment advance decode ----------------
    always_comb
    begin
        do_adv        = 1'b0;
        adv_from_head = 1'b0;
        emit          = 1'b0;
        end_mark      = 1'b0;
        open_pre      = open_reg;
        case (phase_reg)
            PH_LACING:
            begin
                if (lace_last)
                begin
                    do_adv        = 1'b1;
                    adv_from_head = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                if (left_reg == 8'd0)
                begin
                    do_adv = 1'b1;
                end
                else
                begin
                    emit = 1'b1;
                    if (left_reg == 8'd1)
                    begin
                        // a full segment keeps the packet open
                        end_mark = !cur_full_reg;
                        open_pre = cur_full_reg;
                        do_adv   = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign adv_have   = adv_from_head ? head_have_nx : mem_have;
    assign adv_ent    = adv_from_head ? head_nx : mem_entry;
    assign adv_zero   = adv_have ? adv_ent.zero_before
                                 : (adv_from_head ? zero_run_lace_nx : zero_run_reg);
    assign adv_closed = open_pre && adv_zero;

    // ---------------- result ----------------
    always_comb
    begin
        res = '0;
        if (!live)
        begin
            res.error_code = err_reg;
        end
        else if (new_err != ERR_OK)
        begin
            res.error_code = new_err;
        end
        else
        begin
            res.has_byte     = emit;
            res.payload_byte = emit ? b : 8'h00;
            res.packet_end   = end_mark || (do_adv && adv_closed);
        end
    end

    // ---------------- next state ----------------
    always_comb
    begin
        phase_next         = phase_reg;
        hdr_cnt_next       = hdr_cnt_reg;
        serial_next        = serial_reg;
        serial_known_next  = serial_known_reg;
        first_pending_next = first_pending_reg;
        seg_total_next     = seg_total_reg;
        lace_cnt_next      = lace_cnt_reg;
        nz_cnt_next        = nz_cnt_reg;
        rd_ptr_next        = rd_ptr_reg;
        zero_run_next      = zero_run_reg;
        head_valid_next    = head_valid_reg;
        head_next          = head_reg;
        left_next          = left_reg;
        cur_full_next      = cur_full_reg;
        open_next          = open_reg;
        fit_base_next      = fit_base_reg;
        pos_next           = pos_reg;
        len_next           = len_reg;
        err_next           = err_reg;
        ram_we             = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            len_next = cfg_data;
        end

        if (fire && live && new_err != ERR_OK)
        begin
            err_next = new_err;
        end

        if (ok)
        begin
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + STREAM_LEN_W'(1);
            end
            case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_cnt_reg >= HDR_SERIAL_LO && hdr_cnt_reg <= HDR_SERIAL_HI &&
                        !serial_known_reg)
                    begin
                        serial_next[{ser_sel, 3'b000} +: 8] = b;
                        if (hdr_cnt_reg == HDR_SERIAL_HI)
                        begin
                            serial_known_next = 1'b1;
                        end
                    end
                    if (hdr_cnt_reg == HDR_SEGS)
                    begin
                        first_pending_next = 1'b0;
                        seg_total_next     = b;
                        lace_cnt_next      = 8'd0;
                        nz_cnt_next        = '0;
                        zero_run_next      = 1'b0;
                        head_valid_next    = 1'b0;
                        fit_base_next      = {1'b0, pos_reg} + FIT_W'(1);
                        hdr_cnt_next       = '0;
                        // a page without segments leaves packet state alone
                        if (b != 8'h00)
                        begin
                            phase_next = PH_LACING;
                        end
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_reg + HDR_CNT_W'(1);
                    end
                end
                PH_LACING:
                begin
                    lace_cnt_next = lace_cnt_reg + 8'd1;
                    fit_base_next = fit_sum;
                    zero_run_next = zero_run_lace_nx;
                    if (lace_nz)
                    begin
                        ram_we      = 1'b1;
                        nz_cnt_next = nz_cnt_reg + CNT_W'(1);
                        if (!head_valid_reg)
                        begin
                            head_valid_next = 1'b1;
                            head_next       = head_nx;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (emit)
                    begin
                        left_next = left_reg - 8'd1;
                        open_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            if (do_adv)
            begin
                open_next = open_pre && !adv_zero;
                if (adv_have)
                begin
                    left_next     = adv_ent.len;
                    cur_full_next = (adv_ent.len == SEG_FULL);
                    // the head entry is entry 0, so the RAM walk starts at 1
                    rd_ptr_next   = adv_from_head ? CNT_W'(1) : rd_ptr_reg + CNT_W'(1);
                    phase_next    = PH_PAYLOAD;
                end
                else
                begin
                    left_next    = 8'd0;
                    phase_next   = PH_HEADER;
                    hdr_cnt_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            hdr_cnt_reg       <= '0;
            serial_known_reg  <= 1'b0;
            first_pending_reg <= 1'b1;
            seg_total_reg     <= 8'd0;
            lace_cnt_reg      <= 8'd0;
            nz_cnt_reg        <= '0;
            rd_ptr_reg        <= '0;
            zero_run_reg      <= 1'b0;
            head_valid_reg    <= 1'b0;
            left_reg          <= 8'd0;
            cur_full_reg      <= 1'b0;
            open_reg          <= 1'b0;
            pos_reg           <= '0;
            len_reg           <= POS_MAX;
            err_reg           <= ERR_OK;
            fwd_reg           <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            hdr_cnt_reg       <= hdr_cnt_next;
            serial_known_reg  <= serial_known_next;
            first_pending_reg <= first_pending_next;
            seg_total_reg     <= seg_total_next;
            lace_cnt_reg      <= lace_cnt_next;
            nz_cnt_reg        <= nz_cnt_next;
            rd_ptr_reg        <= rd_ptr_next;
            zero_run_reg      <= zero_run_next;
            head_valid_reg    <= head_valid_next;
            left_reg          <= left_next;
            cur_full_reg      <= cur_full_next;
            open_reg          <= open_next;
            pos_reg           <= pos_next;
            len_reg           <= len_next;
            err_reg           <= err_next;
            fwd_reg           <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        serial_reg   <= serial_next;
        head_reg     <= head_next;
        fit_base_reg <= fit_base_next;
        fwd_data_reg <= ram_wdata;
    end

    opd_ram
    #(
        .WIDTH ($bits(opd_entry_t)),
        .DEPTH (MAX_SEGMENTS)
    )
    u_lace_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    opd_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (buf_ready),
        .in_data   (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (buf_out)
    );

    assign m_axis_tdata = {6'b000000, buf_out.error_code, buf_out.payload_byte};
    assign m_axis_tuser = buf_out.has_byte;
    assign m_axis_tlast = buf_out.packet_end;

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != ERR_OK |=> err_reg == $past(err_reg))
        else $error("sticky error changed");

    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> left_reg != 8'd0)
        else $error("payload phase with no bytes left in segment");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> rd_ptr_reg <= nz_cnt_reg)
        else $error("lacing read pointer past stored entries");

    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.error_code != ERR_OK |-> !res.has_byte && !res.packet_end)
        else $error("error result carries payload or end mark");

endmodule

@@ test/ogg_page_packet_deframer_core_tb.sv @@
// Self-checking testbench for the Ogg page deframer core: Ogg page streams in, payload checked.
module ogg_page_packet_deframer_core_tb;
    import opd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HDR_LEN         = 27;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int RAND_ITEMS      = 1250;

    typedef enum logic [1:0] {
        FILL_RAND  = 2'd0,
        FILL_ZERO  = 2'd1,
        FILL_ONES  = 2'd2,
        FILL_COUNT = 2'd3
    } fill_t;

    // one directed page: segment count, lacing values (last lane repeats), payload pattern
    typedef struct packed {
        logic [7:0]      nseg;
        logic [3:0][7:0] lace;
        fill_t           fill;
    } page_row_t;

    typedef enum int {
        END_MAGIC, END_VERSION, END_FLAGS, END_SERIAL,
        END_BEYOND, END_ZERO_LEN, END_LONG_PAGE, END_EXACT_FIT, END_NO_BOS
    } ending_t;

    localparam opd_result_t RES_IDLE = '{1'b0, 8'h00, 1'b0, ERR_OK};

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [STREAM_LEN_W-1:0] cfg_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [7:0]              s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b1;
    logic [15:0]             m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    m_axis_tlast;

    ogg_page_packet_deframer_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // ---------------- deframer predictor state ----------------
    logic [STREAM_LEN_W-1:0] pg_limit        = POS_MAX;
    opd_phase_t              pg_phase        = PH_HEADER;
    logic [HDR_CNT_W-1:0]    pg_hdr_idx      = '0;
    logic [7:0]              pg_flags        = '0;
    logic [31:0]             pg_serial       = '0;
    bit                      pg_serial_valid = 1'b0;
    bit                      pg_need_bos     = 1'b1;
    logic [7:0]              pg_nsegs        = '0;
    logic [7:0]              pg_lace [OPD_MAX_SEGMENTS];
    logic [8:0]              pg_seg_idx      = '0;
    logic [7:0]              pg_seg_remain   = '0;
    bit                      pg_open         = 1'b0;
    logic [16:0]             pg_body_len     = '0;
    logic [STREAM_LEN_W-1:0] pg_pos          = '0;
    opd_err_t                pg_err          = ERR_OK;

    // ---------------- stimulus / scoreboard state ----------------
    opd_result_t want_q [$];
    bit          cur_fixed = 1'b0;
    opd_result_t cur_want = RES_IDLE;
    bit          quiet = 1'b0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          n_in = 0, n_out = 0, n_bad = 0, n_pages = 0;

    logic [7:0]  lace_buf [OPD_MAX_SEGMENTS];
    logic [7:0]  page_q [$];
    bit          gen_open = 1'b0;
    bit          gen_first = 1'b1;
    logic [31:0] gen_serial;
    page_row_t   dir_rows [13];

    function automatic bit page_in_bounds();
        logic [FIT_W-1:0] ofs;
        ofs = {1'b0, pg_pos} + 1'b1;
        if (ofs > {1'b0, pg_limit}) return 1'b0;
        return {24'b0, pg_body_len} <= ({1'b0, pg_limit} - ofs);
    endfunction

    // skip zero segments, load the next nonzero one; 1 if a zero segment closed a packet
    function automatic bit next_segment();
        bit closed;
        closed = 1'b0;
        while (pg_seg_idx < pg_nsegs && pg_seg_idx < OPD_MAX_SEGMENTS &&
               pg_lace[pg_seg_idx] == 8'h00) begin
            pg_seg_idx++;
            if (pg_open) begin
                pg_open = 1'b0;
                closed  = 1'b1;
            end
        end
        if (pg_seg_idx < pg_nsegs && pg_seg_idx < OPD_MAX_SEGMENTS) begin
            pg_seg_remain = pg_lace[pg_seg_idx];
            pg_seg_idx++;
        end
        else begin
            pg_seg_remain = '0;
            pg_phase      = PH_HEADER;
            pg_hdr_idx    = '0;
        end
        return closed;
    endfunction

    function automatic opd_result_t deframe_byte(input logic [7:0] b);
        opd_result_t          r;
        opd_err_t             e;
        logic [HDR_CNT_W-1:0] n;
        int                   lane;
        r = RES_IDLE;
        e = ERR_OK;
        n = pg_hdr_idx;
        if (pg_err != ERR_OK) begin
            e = pg_err;
        end
        else if (pg_pos >= pg_limit) begin
            e = ERR_TRUNC;
        end
        else if (pg_phase == PH_LACING) begin
            if (pg_seg_idx < OPD_MAX_SEGMENTS) pg_lace[pg_seg_idx] = b;
            pg_body_len += b;
            pg_seg_idx++;
            if (pg_seg_idx >= pg_nsegs) begin
                if (!page_in_bounds()) begin
                    e = ERR_TRUNC;
                end
                else begin
                    pg_seg_idx = '0;
                    pg_phase   = PH_PAYLOAD;
                    if (next_segment()) r.packet_end = 1'b1;
                end
            end
        end
        else if (pg_phase == PH_PAYLOAD) begin
            if (pg_seg_remain == 0) begin
                if (next_segment()) r.packet_end = 1'b1;
            end
            else begin
                r.has_byte     = 1'b1;
                r.payload_byte = b;
                pg_open        = 1'b1;
                pg_seg_remain--;
                if (pg_seg_remain == 0) begin
                    // a segment shorter than 255 ends its packet
                    if (pg_lace[pg_seg_idx - 1] != SEG_FULL) begin
                        r.packet_end = 1'b1;
                        pg_open      = 1'b0;
                    end
                    if (next_segment()) r.packet_end = 1'b1;
                end
            end
        end
        else begin
            if (n <= HDR_MAGIC_HI) begin
                if (b != OGG_MAGIC[n[1:0]]) e = ERR_HEADER;
            end
            else if (n == HDR_VERSION) begin
                if (b != 8'h00) e = ERR_HEADER;
            end
            else if (n == HDR_FLAGS) begin
                if (b[FLAG_CONT_BIT] != pg_open) e = ERR_HEADER;
                else if (pg_need_bos && !b[FLAG_BOS_BIT]) e = ERR_HEADER;
                pg_flags = b;
            end
            else if (n >= HDR_SERIAL_LO && n <= HDR_SERIAL_HI) begin
                lane = int'(n) - int'(HDR_SERIAL_LO);
                if (pg_serial_valid) begin
                    if (pg_serial[8*lane +: 8] != b) e = ERR_SERIAL;
                end
                else begin
                    pg_serial[8*lane +: 8] = b;
                    if (n == HDR_SERIAL_HI) pg_serial_valid = 1'b1;
                end
            end
            else if (n >= HDR_SEGS) begin
                pg_need_bos   = 1'b0;
                pg_nsegs      = b;
                pg_seg_idx    = '0;
                pg_seg_remain = '0;
                pg_body_len   = '0;
                if (b == 8'h00) begin
                    if (!page_in_bounds()) e = ERR_TRUNC;
                    pg_hdr_idx = '0;
                end
                else begin
                    pg_phase = PH_LACING;
                end
            end
            if (e == ERR_OK && n < HDR_SEGS) pg_hdr_idx = n + 1'b1;
        end

        if (pg_err == ERR_OK && e != ERR_OK) begin
            pg_err = e;
            r      = RES_IDLE;
        end
        if (pg_err == ERR_OK && pg_pos != POS_MAX) pg_pos++;
        r.error_code = e;
        return r;
    endfunction

    // ---------------- monitor, scoreboard, watchdog ----------------
    always @(posedge clk) begin : monitor
        opd_result_t got;
        opd_result_t want;
        bit          moved;
        if (rst_n) begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready) begin
                pg_limit = cfg_data;
                moved    = 1'b1;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                got = deframe_byte(s_axis_tdata);
                want_q.push_back(cur_fixed ? cur_want : got);
                n_in++;
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                n_out++;
                stall_left = quiet ? 0 : $urandom_range(0, 3);
                if (want_q.size() == 0) begin
                    if (n_bad < 10)
                        $display("%0t: result with nothing expected: has=%0d byte=%02h end=%0d err=%0d",
                                 $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast,
                                 m_axis_tdata[9:8]);
                    n_bad++;
                end
                else begin
                    want = want_q.pop_front();
                    if (m_axis_tuser !== want.has_byte || m_axis_tdata[7:0] !== want.payload_byte ||
                        m_axis_tlast !== want.packet_end || m_axis_tdata[9:8] !== want.error_code)
                    begin
                        if (n_bad < 10)
                            $display("%0t: result %0d expected has=%0d byte=%02h end=%0d err=%0d, got has=%0d byte=%02h end=%0d err=%0d",
                                     $time, n_out, want.has_byte, want.payload_byte,
                                     want.packet_end, want.error_code, m_axis_tuser,
                                     m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[9:8]);
                        n_bad++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // output backpressure
    always @(negedge clk) begin
        if (stall_left > 0) begin
            m_axis_tready = 1'b0;
            stall_left--;
        end
        else begin
            m_axis_tready = 1'b1;
        end
    end

    // ---------------- drivers ----------------
    task automatic send_byte(input logic [7:0] b, input bit fixed, input opd_result_t want);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        cur_fixed     = fixed;
        cur_want      = want;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // stop sending and wait until every result is in
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (want_q.size() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_stream_len(input logic [STREAM_LEN_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // well-formed page from lace_buf; tracks whether a packet stays open
    task automatic build_page(input int nseg, input fill_t fill);
        logic [7:0] flags;
        int         k;
        page_q.delete();
        quiet = ($urandom_range(0, 4) == 0);
        flags = 8'($urandom);
        flags[FLAG_CONT_BIT] = gen_open;
        if (gen_first) flags[FLAG_BOS_BIT] = 1'b1;
        for (int i = 0; i < 4; i++) page_q.push_back(OGG_MAGIC[i]);
        page_q.push_back(8'h00);
        page_q.push_back(flags);
        repeat (8) page_q.push_back(8'($urandom));
        for (int i = 0; i < 4; i++) page_q.push_back(gen_serial[8*i +: 8]);
        repeat (8) page_q.push_back(8'($urandom));
        page_q.push_back(8'(nseg));
        for (int i = 0; i < nseg; i++) page_q.push_back(lace_buf[i]);
        k = 0;
        for (int i = 0; i < nseg; i++) begin
            for (int j = 0; j < lace_buf[i]; j++) begin
                case (fill)
                    FILL_ZERO:  page_q.push_back(8'h00);
                    FILL_ONES:  page_q.push_back(8'hFF);
                    FILL_COUNT: page_q.push_back(8'(k));
                    default:    page_q.push_back(8'($urandom));
                endcase
                k++;
            end
            if (lace_buf[i] == 8'h00) gen_open = 1'b0;
            else gen_open = (lace_buf[i] == SEG_FULL);
        end
        gen_first = 1'b0;
        n_pages++;
    endtask

    // header bytes of directed pages are plainly all-zero results
    task automatic send_page(input bit directed);
        foreach (page_q[i]) send_byte(page_q[i], directed && i < HDR_LEN, RES_IDLE);
    endtask

    task automatic rand_lacing(input int nseg);
        int r;
        for (int i = 0; i < nseg; i++) begin
            r = $urandom_range(0, 11);
            if (nseg > 16)   lace_buf[i] = 8'($urandom_range(0, 3));
            else if (r == 0) lace_buf[i] = 8'h00;
            else if (r == 1) lace_buf[i] = SEG_FULL;
            else if (r == 2) lace_buf[i] = 8'($urandom_range(0, 254));
            else             lace_buf[i] = 8'($urandom_range(1, 30));
        end
    endtask

    function automatic page_row_t mk_row(input int nseg, input logic [7:0] l0, input logic [7:0] l1,
                                         input logic [7:0] l2, input logic [7:0] l3,
                                         input fill_t f);
        page_row_t r;
        r.nseg    = 8'(nseg);
        r.lace[0] = l0;
        r.lace[1] = l1;
        r.lace[2] = l2;
        r.lace[3] = l3;
        r.fill    = f;
        return r;
    endfunction

    initial begin : main
        page_row_t   row;
        ending_t     scen;
        int          nseg, r, bad_idx, sum, rand_bytes;
        bit          mid_done;
        logic [7:0]  bad_xor;
        opd_err_t    bad_code;
        opd_result_t fail_res;

        gen_serial = $urandom;
        dir_rows[0]  = mk_row(1,   8'd5,   8'd5,   8'd5,   8'd5,   FILL_ZERO);  // first page
        dir_rows[1]  = mk_row(0,   8'd0,   8'd0,   8'd0,   8'd0,   FILL_RAND);  // no segments
        dir_rows[2]  = mk_row(1,   8'd0,   8'd0,   8'd0,   8'd0,   FILL_RAND);  // empty packet
        dir_rows[3]  = mk_row(2,   8'd255, 8'd0,   8'd0,   8'd0,   FILL_ONES);  // zero closes in page
        dir_rows[4]  = mk_row(1,   8'd255, 8'd255, 8'd255, 8'd255, FILL_COUNT); // left open
        dir_rows[5]  = mk_row(0,   8'd0,   8'd0,   8'd0,   8'd0,   FILL_RAND);  // empty, still open
        dir_rows[6]  = mk_row(1,   8'd0,   8'd0,   8'd0,   8'd0,   FILL_RAND);  // closes on lacing
        dir_rows[7]  = mk_row(2,   8'd255, 8'd255, 8'd0,   8'd0,   FILL_RAND);
        dir_rows[8]  = mk_row(3,   8'd1,   8'd0,   8'd0,   8'd0,   FILL_ONES);
        dir_rows[9]  = mk_row(255, 8'd1,   8'd1,   8'd1,   8'd1,   FILL_COUNT); // max segments
        dir_rows[10] = mk_row(4,   8'd0,   8'd0,   8'd255, 8'd0,   FILL_RAND);
        dir_rows[11] = mk_row(3,   8'd255, 8'd7,   8'd255, 8'd255, FILL_RAND);
        dir_rows[12] = mk_row(2,   8'd0,   8'd3,   8'd3,   8'd3,   FILL_ZERO);

        r    = $urandom_range(0, 16);
        scen = (r == 16) ? END_NO_BOS : ending_t'(r % 8);

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        write_stream_len(POS_MAX);
        if (scen != END_NO_BOS) begin
            foreach (dir_rows[k]) begin
                row = dir_rows[k];
                for (int i = 0; i < row.nseg; i++) lace_buf[i] = row.lace[i < 3 ? i : 3];
                build_page(row.nseg, row.fill);
                send_page(1'b1);
            end

            write_stream_len({1'b1, 39'($urandom), 7'($urandom)} | 40'h80_0000_0000);
            rand_bytes = 0;
            mid_done   = 1'b0;
            while (rand_bytes < RAND_ITEMS) begin
                if (!mid_done && rand_bytes > RAND_ITEMS / 2) begin
                    drain();
                    write_stream_len(pg_pos + 40'd100000 + 40'($urandom_range(0, 1000)));
                    mid_done = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 8)       nseg = 0;
                else if (r < 75) nseg = $urandom_range(1, 4);
                else if (r < 97) nseg = $urandom_range(5, 16);
                else             nseg = $urandom_range(17, 255);
                rand_lacing(nseg);
                build_page(nseg, FILL_RAND);
                send_page(1'b0);
                rand_bytes += page_q.size();
            end
        end

        // closing case: one error, then everything after it must carry the same code
        drain();
        bad_xor  = 8'h00;
        bad_code = ERR_HEADER;
        if (scen == END_LONG_PAGE) begin
            nseg = $urandom_range(1, 4);
            for (int i = 0; i < nseg; i++) lace_buf[i] = 8'($urandom_range(1, 50));
        end
        else begin
            nseg = $urandom_range(0, 4);
            rand_lacing(nseg);
        end
        build_page(nseg, FILL_RAND);
        sum = page_q.size() - HDR_LEN - nseg;
        case (scen)
            END_MAGIC: begin
                bad_idx = $urandom_range(0, 3);
                bad_xor = 8'h01 << $urandom_range(0, 7);
            end
            END_VERSION: begin
                bad_idx = int'(HDR_VERSION);
                bad_xor = 8'($urandom_range(1, 255));
            end
            END_FLAGS: begin
                bad_idx = int'(HDR_FLAGS);
                bad_xor = 8'h01 << FLAG_CONT_BIT;
            end
            END_NO_BOS: begin
                bad_idx = int'(HDR_FLAGS);
                bad_xor = 8'h01 << FLAG_BOS_BIT;
            end
            END_SERIAL: begin
                bad_idx  = int'(HDR_SERIAL_LO) + $urandom_range(0, 3);
                bad_xor  = 8'h01 << $urandom_range(0, 7);
                bad_code = ERR_SERIAL;
            end
            END_BEYOND: begin
                write_stream_len(pg_pos);
                bad_idx  = 0;
                bad_code = ERR_TRUNC;
            end
            END_ZERO_LEN: begin
                write_stream_len('0);
                bad_idx  = 0;
                bad_code = ERR_TRUNC;
            end
            END_LONG_PAGE: begin
                // payload overshoots the stream by one byte; caught on the last lacing byte
                write_stream_len(pg_pos + 40'(HDR_LEN + nseg + sum - 1));
                bad_idx  = HDR_LEN + nseg - 1;
                bad_code = ERR_TRUNC;
            end
            default: begin
                // page ends exactly at the stream end; the byte after it is truncated
                write_stream_len(pg_pos + 40'(page_q.size()));
                bad_idx = page_q.size();
                page_q.push_back(OGG_MAGIC[0]);
                bad_code = ERR_TRUNC;
            end
        endcase
        for (int i = 0; i < bad_idx; i++) send_byte(page_q[i], 1'b0, RES_IDLE);
        fail_res            = RES_IDLE;
        fail_res.error_code = bad_code;
        send_byte(page_q[bad_idx] ^ bad_xor, 1'b1, fail_res);
        repeat (12) send_byte(8'($urandom), 1'b1, fail_res);
        write_stream_len('0);
        repeat (4) send_byte(8'($urandom), 1'b1, fail_res);
        write_stream_len(POS_MAX);
        repeat (4) send_byte(8'($urandom), 1'b1, fail_res);
        drain();

        $display("Ran %0d pages, %0d items in, %0d results checked; closing case %s",
                 n_pages, n_in, n_out, scen.name());
        $display("Mismatches: %0d", n_bad);
        if (n_bad == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
